@@ src/mbe_pkg.sv @@
package mbe_pkg;

    // fixed point format
    localparam int FRAC_BITS = 14;

    // width of c = scaling * coord + offset (19 bit product plus 16 bit signed offset)
    localparam int C_W = 21;
    // width of z; a point that has not escaped stays well inside this range
    localparam int Z_W = 24;
    // width of the full square and cross products
    localparam int P_W = 2 * Z_W;

    // escape bound 4 << FRAC_BITS
    localparam logic signed [P_W:0] ESC_BOUND = (P_W + 1)'(64'sd4 <<< FRAC_BITS);

    localparam int CNT_W = 16;
    localparam int LIM_W = 17;
    localparam int SHADE_W = 4;
    localparam logic [SHADE_W-1:0] SHADE_MAX = 4'd15;

    // configuration register map
    localparam int ADDR_W = 5;
    localparam int RIDX_W = 3;
    localparam logic [RIDX_W-1:0] REG_SCALING = 3'd0;
    localparam logic [RIDX_W-1:0] REG_OFFSET_REAL = 3'd1;
    localparam logic [RIDX_W-1:0] REG_OFFSET_IMAG = 3'd2;
    localparam logic [RIDX_W-1:0] REG_MAX_COUNT = 3'd3;
    localparam logic [RIDX_W-1:0] REG_DIVISOR = 3'd4;

    // point c of one pixel, queued between front and back
    typedef struct packed {
        logic signed [C_W-1:0] cr;
        logic signed [C_W-1:0] ci;
    } cpt_t;

    // finished iteration handed to the shade stage
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] count;
    } iter_res_t;

    // view of the configuration used by the front
    typedef struct packed {
        logic [9:0]         scaling;
        logic signed [15:0] offset_real;
        logic signed [15:0] offset_imag;
    } front_cfg_t;

endpackage

@@ src/mbe_front.sv @@
module mbe_front
    import mbe_pkg::*;
(
    input  front_cfg_t cfg,
    input  logic [8:0] column,
    input  logic [8:0] row,
    output cpt_t       pt
);

    logic [18:0] prod_r;
    logic [18:0] prod_i;

    // coordinates are unsigned, product always fits 19 bits
    assign prod_r = {9'd0, cfg.scaling} * {10'd0, column};
    assign prod_i = {9'd0, cfg.scaling} * {10'd0, row};

    assign pt.cr = {2'b00, prod_r} + {{(C_W-16){cfg.offset_real[15]}}, cfg.offset_real};
    assign pt.ci = {2'b00, prod_i} + {{(C_W-16){cfg.offset_imag[15]}}, cfg.offset_imag};

endmodule

@@ src/mbe_fifo.sv @@
module mbe_fifo
    import mbe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cpt_t push_data,
    input  logic pop,
    output cpt_t pop_data,
    output logic full,
    output logic empty
);

    cpt_t       mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign full = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/mbe_iter.sv @@
module mbe_iter
    import mbe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] steps_max,
    input  logic             q_empty,
    input  cpt_t             q_data,
    output logic             q_pop,
    output iter_res_t        res
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } iter_st_t;

    iter_st_t              st_reg;
    iter_st_t              st_next;
    logic signed [Z_W-1:0] zr_reg;
    logic signed [Z_W-1:0] zr_next;
    logic signed [Z_W-1:0] zi_reg;
    logic signed [Z_W-1:0] zi_next;
    logic [CNT_W-1:0]      n_reg;
    logic [CNT_W-1:0]      n_next;
    cpt_t                  c_reg;
    cpt_t                  c_next;

    logic signed [P_W-1:0] m1;
    logic signed [P_W-1:0] m2;
    logic signed [P_W-1:0] m3;
    logic signed [P_W:0]   sq_diff;
    logic signed [P_W:0]   sq_sum;
    logic signed [P_W:0]   diff_sh;
    logic signed [P_W:0]   sum_sh;
    logic signed [P_W-1:0] m3_sh;
    logic                  at_limit;
    logic                  escaped;

    // one complex square-and-add per cycle while running
    assign m1 = zr_reg * zr_reg;
    assign m2 = zi_reg * zi_reg;
    assign m3 = zr_reg * zi_reg;
    assign sq_diff = {m1[P_W-1], m1} - {m2[P_W-1], m2};
    assign sq_sum = {m1[P_W-1], m1} + {m2[P_W-1], m2};
    assign diff_sh = sq_diff >>> FRAC_BITS;
    assign sum_sh = sq_sum >>> FRAC_BITS;
    assign m3_sh = m3 >>> (FRAC_BITS - 1);

    assign at_limit = (n_reg == steps_max);
    assign escaped = (sum_sh > ESC_BOUND);

    assign q_pop = (st_reg == ST_IDLE) && !q_empty;

    always_comb
    begin
        st_next = st_reg;
        zr_next = zr_reg;
        zi_next = zi_reg;
        n_next = n_reg;
        c_next = c_reg;
        res.valid = 1'b0;
        res.count = n_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    st_next = ST_RUN;
                    c_next = q_data;
                    zr_next = '0;
                    zi_next = '0;
                    n_next = '0;
                end
            end
            ST_RUN:
            begin
                // limit checked before the step, escape on the old squares
                if (at_limit || escaped)
                begin
                    res.valid = 1'b1;
                    st_next = ST_IDLE;
                end
                else
                begin
                    zr_next = diff_sh[Z_W-1:0] + {{(Z_W-C_W){c_reg.cr[C_W-1]}}, c_reg.cr};
                    zi_next = m3_sh[Z_W-1:0] + {{(Z_W-C_W){c_reg.ci[C_W-1]}}, c_reg.ci};
                    n_next = n_reg + 1'b1;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zr_reg <= zr_next;
        zi_reg <= zi_next;
        n_reg <= n_next;
        c_reg <= c_next;
    end

endmodule

@@ src/mbe_shade.sv @@
module mbe_shade
    import mbe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  iter_res_t          res,
    input  logic [15:0]        divisor,
    output logic               done,
    output logic [CNT_W-1:0]   escape_count,
    output logic [SHADE_W-1:0] shade
);

    logic               done_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [SHADE_W-1:0] shade_reg;
    logic [SHADE_W-1:0] shade_next;
    logic [SHADE_W-1:0] log_len;
    logic [SHADE_W-1:0] quo;
    logic [19:0]        rem;
    logic [19:0]        div_ext;
    logic               quo_sat;

    // bit length, saturated once bit 14 or above is set
    always_comb
    begin
        log_len = '0;
        for (int i = 0; i < 14; i++)
        begin
            if (res.count[i])
            begin
                log_len = SHADE_W'(i + 1);
            end
        end
        if (res.count[15:14] != 2'b00)
        begin
            log_len = SHADE_MAX;
        end
    end

    // four-bit restoring division, saturated when the quotient reaches 16
    always_comb
    begin
        div_ext = {4'd0, divisor};
        rem = {4'd0, res.count};
        quo = '0;
        quo_sat = (rem >= (div_ext << 4));
        for (int i = 3; i >= 0; i--)
        begin
            if (rem >= (div_ext << i))
            begin
                rem = rem - (div_ext << i);
                quo[i] = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (divisor == 16'd0)
        begin
            shade_next = log_len;
        end
        else if (quo_sat)
        begin
            shade_next = SHADE_MAX;
        end
        else
        begin
            shade_next = quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            count_reg <= res.count;
            shade_reg <= shade_next;
        end
    end

    assign done = done_reg;
    assign escape_count = count_reg;
    assign shade = shade_reg;

endmodule

@@ src/mandelbrot_pixel_escape_shade.sv @@
// a pixel accepted while the back end is idle goes through the point queue, the
//   iterator and the registered shade stage, which raises done with its result
// the single z^2 + c unit iterates one pixel at a time; the next waits in the queue
// start is taken while the two-entry point queue has room; busy means it is full
// rst_n is asynchronous and active low: config returns to its reset values, queue
//   and iterator empty; results are strobed on done and cannot be stalled
module mandelbrot_pixel_escape_shade
    import mbe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // pixel command
    input  logic               start,
    output logic               busy,
    input  logic [8:0]         column,
    input  logic [8:0]         row,
    // result
    output logic               done,
    output logic [CNT_W-1:0]   escape_count,
    output logic [SHADE_W-1:0] shade,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [9:0]         scaling_reg;
    logic signed [15:0] offset_real_reg;
    logic signed [15:0] offset_imag_reg;
    logic [LIM_W-1:0]   max_count_reg;
    logic [15:0]        divisor_reg;

    logic               cfg_wr;
    logic [RIDX_W-1:0]  reg_idx;
    logic [CNT_W-1:0]   steps_max;

    front_cfg_t         front_cfg;
    cpt_t               new_pt;
    cpt_t               head_pt;
    logic               q_full;
    logic               q_empty;
    logic               q_pop;
    logic               accept;
    iter_res_t          iter_res;

    // ------------------------------------------------------------------
    // register port: no wait states, word addressed
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scaling_reg <= 10'd1;
            offset_real_reg <= 16'sd0;
            offset_imag_reg <= 16'sd0;
            max_count_reg <= 17'd64;
            divisor_reg <= 16'd4;
        end
        else if (cfg_wr)
        begin
            // writes to unmapped indexes fall through and are dropped
            case (reg_idx)
                REG_SCALING:     scaling_reg <= pwdata[9:0];
                REG_OFFSET_REAL: offset_real_reg <= pwdata[15:0];
                REG_OFFSET_IMAG: offset_imag_reg <= pwdata[15:0];
                REG_MAX_COUNT:   max_count_reg <= pwdata[LIM_W-1:0];
                REG_DIVISOR:     divisor_reg <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SCALING:     prdata = {22'd0, scaling_reg};
            REG_OFFSET_REAL: prdata = {{16{offset_real_reg[15]}}, offset_real_reg};
            REG_OFFSET_IMAG: prdata = {{16{offset_imag_reg[15]}}, offset_imag_reg};
            REG_MAX_COUNT:   prdata = {{(32-LIM_W){1'b0}}, max_count_reg};
            REG_DIVISOR:     prdata = {16'd0, divisor_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // number of steps allowed: a limit of zero acts as one, anything past
    // 65536 is clipped so the count always fits 16 bits
    always_comb
    begin
        if (max_count_reg == '0)
        begin
            steps_max = '0;
        end
        else if (max_count_reg[LIM_W-1])
        begin
            steps_max = '1;
        end
        else
        begin
            steps_max = CNT_W'(max_count_reg - 1'b1);
        end
    end

    // ------------------------------------------------------------------
    // front: form c for the pixel and queue it
    // ------------------------------------------------------------------
    assign busy = q_full;
    assign accept = start && !busy;

    assign front_cfg.scaling = scaling_reg;
    assign front_cfg.offset_real = offset_real_reg;
    assign front_cfg.offset_imag = offset_imag_reg;

    mbe_front u_front (
        .cfg    (front_cfg),
        .column (column),
        .row    (row),
        .pt     (new_pt)
    );

    // decouples pixel intake from the iteration loop
    mbe_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (new_pt),
        .pop       (q_pop),
        .pop_data  (head_pt),
        .full      (q_full),
        .empty     (q_empty)
    );

    // ------------------------------------------------------------------
    // back: escape-time loop, then shading and the result strobe
    // ------------------------------------------------------------------
    mbe_iter u_iter (
        .clk       (clk),
        .rst_n     (rst_n),
        .steps_max (steps_max),
        .q_empty   (q_empty),
        .q_data    (head_pt),
        .q_pop     (q_pop),
        .res       (iter_res)
    );

    mbe_shade u_shade (
        .clk          (clk),
        .rst_n        (rst_n),
        .res          (iter_res),
        .divisor      (divisor_reg),
        .done         (done),
        .escape_count (escape_count),
        .shade        (shade)
    );

endmodule

@@ src/mbe_checker.sv @@
module mbe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [15:0] escape_count,
    input logic [3:0]  shade,
    input logic        pready
);

    logic [2:0] pend_reg;
    logic [2:0] pend_next;
    logic       acc;

    assign acc = start && !busy;

    // transactions accepted but not yet answered
    always_comb
    begin
        pend_next = pend_reg;
        if (acc && !done)
        begin
            pend_next = pend_reg + 3'd1;
        end
        else if (done && !acc)
        begin
            pend_next = pend_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 3'd0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pend_reg != 3'd0))
        else $error("result without an accepted transaction");

    a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg == 3'd0) |-> !busy)
        else $error("busy with nothing in flight");

    a_zero_count_shade: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (escape_count == 16'd0)) |-> (shade == 4'd0))
        else $error("nonzero shade for zero count");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd4)
        else $error("too many transactions in flight");

endmodule

bind mandelbrot_pixel_escape_shade mbe_checker u_mbe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .escape_count (escape_count),
    .shade        (shade),
    .pready       (pready)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import mbe_pkg::*;

    // cycles without an accepted pixel, result or register access before the run is declared hung;
    // the slowest pixel takes 65535 steps
    localparam int WATCHDOG_LIMIT = 300000;
    // quiet cycles after the last result before registers change
    localparam int SETTLE_CYCLES = 4;
    // quiet cycles at the very end to catch stray results
    localparam int TAIL_CYCLES = 16;
    localparam int SWEEP_PHASES = 6;
    localparam int PHASE_ITEMS = 250;
    localparam int IMAGE_WIDTH = 400;
    localparam int IMAGE_HEIGHT = 300;

    // expected outcome of one pixel
    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic [SHADE_W-1:0] shade;
    } escape_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [8:0]         column = '0;
    logic [8:0]         row = '0;
    logic               done;
    logic [CNT_W-1:0]   escape_count;
    logic [SHADE_W-1:0] shade;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // shadow copy of the register file, starting at the reset values
    logic [9:0]         cfg_scaling = 10'd1;
    logic signed [15:0] cfg_offset_real = 16'sd0;
    logic signed [15:0] cfg_offset_imag = 16'sd0;
    logic [16:0]        cfg_max_count = 17'd64;
    logic [15:0]        cfg_divisor = 16'd4;

    // outcomes of accepted pixels, oldest first
    escape_t escape_fifo[$];
    int      errors = 0;

    mandelbrot_pixel_escape_shade uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // escape-time iteration in 64-bit signed arithmetic; >>> on longint floors
    function automatic escape_t compute_escape(input logic [8:0] col, input logic [8:0] rw);
        longint      cr;
        longint      ci;
        longint      zr;
        longint      zi;
        longint      sq_r;
        longint      sq_i;
        longint      prod_ri;
        longint      bound;
        int unsigned limit;
        int unsigned steps;
        int unsigned len;
        int unsigned rest;
        int unsigned level;
        escape_t     res;
        cr = longint'(cfg_scaling) * longint'(col) + longint'(cfg_offset_real);
        ci = longint'(cfg_scaling) * longint'(rw) + longint'(cfg_offset_imag);
        bound = longint'(4) <<< FRAC_BITS;
        limit = cfg_max_count;
        // a zero limit acts as one, anything above 65536 saturates
        if (limit == 0)
        begin
            limit = 1;
        end
        if (limit > 65536)
        begin
            limit = 65536;
        end
        zr = 0;
        zi = 0;
        steps = 0;
        while (steps < limit - 1)
        begin
            sq_r = zr * zr;
            sq_i = zi * zi;
            prod_ri = zi * zr;
            zr = ((sq_r - sq_i) >>> FRAC_BITS) + cr;
            zi = (prod_ri >>> (FRAC_BITS - 1)) + ci;
            // escape is judged on the squares of the old z, that step not counted
            if (((sq_r + sq_i) >>> FRAC_BITS) > bound)
            begin
                break;
            end
            steps++;
        end
        if (cfg_divisor == 0)
        begin
            // log shading: bit length of the count
            len = 0;
            rest = steps;
            while (rest != 0)
            begin
                len++;
                rest = rest >> 1;
            end
            level = len;
        end
        else
        begin
            level = steps / cfg_divisor;
        end
        if (level > SHADE_MAX)
        begin
            level = SHADE_MAX;
        end
        res.count = CNT_W'(steps);
        res.shade = SHADE_W'(level);
        return res;
    endfunction

    // one register write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [RIDX_W-1:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_SCALING:     cfg_scaling = data[9:0];
            REG_OFFSET_REAL: cfg_offset_real = data[15:0];
            REG_OFFSET_IMAG: cfg_offset_imag = data[15:0];
            REG_MAX_COUNT:   cfg_max_count = data[16:0];
            REG_DIVISOR:     cfg_divisor = data[15:0];
            default:         ;
        endcase
    endtask

    // present one pixel and hold it until the block takes it; start stays high
    // on return so a following pixel goes out back to back
    task automatic issue_pixel(input logic [8:0] col, input logic [8:0] rw);
        column <= col;
        row <= rw;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        escape_fifo.push_back(compute_escape(col, rw));
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // mostly pixels inside the image, some anywhere in the 9-bit range
    task automatic issue_random_pixel();
        if ($urandom_range(0, 7) == 0)
        begin
            issue_pixel(9'($urandom), 9'($urandom));
        end
        else
        begin
            issue_pixel(9'($urandom_range(0, IMAGE_WIDTH - 1)),
                        9'($urandom_range(0, IMAGE_HEIGHT - 1)));
        end
    endtask

    // stop sending and wait until every outstanding pixel has answered
    task automatic drain_pixels();
        start <= 1'b0;
        do @(posedge clk); while (escape_fifo.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // new register set for one random phase, with junk in the unused data bits
    task automatic randomize_config();
        logic [9:0]         scl;
        logic signed [15:0] ore;
        logic signed [15:0] oim;
        logic [16:0]        lim;
        logic [15:0]        div;
        int                 pick;
        if ($urandom_range(0, 4) < 3)
        begin
            // window over the interesting part of the set
            scl = 10'($urandom_range(40, 140));
            ore = 16'(-32768 + int'($urandom_range(0, 8192)));
            oim = 16'(-(int'(scl) * 150) + int'($urandom_range(0, 2000)) - 1000);
        end
        else
        begin
            scl = 10'($urandom);
            ore = 16'($urandom);
            oim = 16'($urandom);
        end
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            lim = 17'($urandom_range(0, 3));
        end
        else if (pick == 1)
        begin
            lim = 17'($urandom_range(200, 400));
        end
        else
        begin
            lim = 17'($urandom_range(2, 160));
        end
        pick = $urandom_range(0, 9);
        if (pick < 3)
        begin
            div = 16'd0;
        end
        else if (pick < 8)
        begin
            div = 16'($urandom_range(1, 20));
        end
        else
        begin
            div = 16'($urandom);
        end
        write_reg(REG_SCALING, {22'($urandom), scl});
        write_reg(REG_OFFSET_REAL, {16'($urandom), ore});
        write_reg(REG_OFFSET_IMAG, {16'($urandom), oim});
        write_reg(REG_MAX_COUNT, {15'($urandom), lim});
        write_reg(REG_DIVISOR, {16'($urandom), div});
    endtask

    // reset values: c is tiny, every pixel stays in the set
    task automatic test_reset_values();
        issue_pixel(9'd0, 9'd0);
        issue_pixel(9'd399, 9'd299);
        issue_pixel(9'd511, 9'd511);
        issue_pixel(9'd256, 9'd128);
        drain_pixels();
    endtask

    // extreme scaling and offsets, the bounce point c = -2 and tiny limits
    task automatic test_corner_config();
        write_reg(REG_SCALING, 32'd1023);
        write_reg(REG_OFFSET_REAL, 32'h0000_7FFF);
        write_reg(REG_OFFSET_IMAG, 32'hFFFF_8000);
        issue_pixel(9'd0, 9'd0);
        issue_pixel(9'd511, 9'd511);
        drain_pixels();
        // c = -2 sits exactly on the escape bound and never leaves
        write_reg(REG_SCALING, 32'd0);
        write_reg(REG_OFFSET_REAL, 32'h0000_8000);
        write_reg(REG_OFFSET_IMAG, 32'd0);
        issue_pixel(9'd123, 9'd45);
        drain_pixels();
        write_reg(REG_OFFSET_IMAG, 32'h0000_8000);
        issue_pixel(9'd0, 9'd0);
        drain_pixels();
        // zero limit behaves as one: no step runs
        write_reg(REG_MAX_COUNT, 32'd0);
        issue_pixel(9'd7, 9'd7);
        drain_pixels();
        write_reg(REG_MAX_COUNT, 32'd1);
        issue_pixel(9'd7, 9'd7);
        drain_pixels();
        write_reg(REG_MAX_COUNT, 32'd2);
        issue_pixel(9'd7, 9'd7);
        drain_pixels();
    endtask

    // limits at and above 65536 give the full 16-bit count
    task automatic test_limit_saturation();
        write_reg(REG_OFFSET_REAL, 32'd0);
        write_reg(REG_OFFSET_IMAG, 32'd0);
        write_reg(REG_MAX_COUNT, 32'h0001_FFFF);
        issue_pixel(9'd3, 9'd3);
        drain_pixels();
        write_reg(REG_OFFSET_REAL, 32'h0000_8000);
        write_reg(REG_MAX_COUNT, 32'h0001_0000);
        issue_pixel(9'd0, 9'd0);
        drain_pixels();
    endtask

    // log shading, unit divisor saturation and a divisor too big to matter
    task automatic test_shading();
        write_reg(REG_SCALING, 32'd80);
        write_reg(REG_OFFSET_REAL, 32'hFFFF_8000);
        write_reg(REG_OFFSET_IMAG, 32'hFFFF_D120);
        write_reg(REG_MAX_COUNT, 32'd64);
        write_reg(REG_DIVISOR, 32'd0);
        issue_pixel(9'd0, 9'd0);
        issue_pixel(9'd300, 9'd150);
        issue_pixel(9'd220, 9'd120);
        drain_pixels();
        write_reg(REG_DIVISOR, 32'd1);
        issue_pixel(9'd300, 9'd150);
        issue_pixel(9'd10, 9'd290);
        drain_pixels();
        write_reg(REG_DIVISOR, 32'd65535);
        issue_pixel(9'd300, 9'd150);
        drain_pixels();
        // log shade of a zero count
        write_reg(REG_DIVISOR, 32'd0);
        write_reg(REG_MAX_COUNT, 32'd1);
        issue_pixel(9'd300, 9'd150);
        drain_pixels();
    endtask

    // writes to unmapped register slots change nothing
    task automatic test_spare_registers();
        for (int i = int'(REG_DIVISOR) + 1; i < (1 << RIDX_W); i++)
        begin
            write_reg(RIDX_W'(i), $urandom);
        end
        issue_pixel(9'd300, 9'd150);
        issue_pixel(9'd50, 9'd250);
        drain_pixels();
    endtask

    // random register sets, each with a stream of pixels and sender gaps
    task automatic test_random_sweep();
        for (int phase = 0; phase < SWEEP_PHASES; phase++)
        begin
            randomize_config();
            repeat (PHASE_ITEMS)
            begin
                issue_random_pixel();
                if ($urandom_range(0, 3) == 0)
                begin
                    pause_sender($urandom_range(1, 7));
                end
            end
            drain_pixels();
        end
    endtask

    // closing stretch: back-to-back pixels, no gaps
    task automatic test_steady_stream();
        randomize_config();
        repeat (PHASE_ITEMS)
        begin
            issue_random_pixel();
        end
        drain_pixels();
    endtask

    // compare every strobed result with the oldest outstanding pixel
    always @(posedge clk)
    begin : result_check
        escape_t want;
        if (rst_n && done)
        begin
            if (escape_fifo.size() == 0)
            begin
                $display("%0t: result with no pixel outstanding: escape_count %0d shade %0d",
                         $time, escape_count, shade);
                errors++;
            end
            else
            begin
                want = escape_fifo.pop_front();
                if (escape_count !== want.count)
                begin
                    $display("%0t: escape_count mismatch: expected %0d actual %0d",
                             $time, want.count, escape_count);
                    errors++;
                end
                if (shade !== want.shade)
                begin
                    $display("%0t: shade mismatch: expected %0d actual %0d",
                             $time, want.shade, shade);
                    errors++;
                end
            end
        end
    end

    // hang detector: any accepted pixel, result or register access restarts it
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done || (psel && penable))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("mandelbrot_pixel_escape_shade regression: fail");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_corner_config();
        test_limit_saturation();
        test_shading();
        test_spare_registers();
        test_random_sweep();
        test_steady_stream();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && escape_fifo.size() == 0)
        begin
            $display("mandelbrot_pixel_escape_shade regression: pass");
        end
        else
        begin
            $display("mandelbrot_pixel_escape_shade regression: fail");
        end
        $finish;
    end

endmodule
